/* rtl/whf_pkg.sv */
package whf_pkg;
   localparam int WAYPOINTS    = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int SLOT_W       = 3;
   localparam int POS_W        = 24;
   localparam int DIFF_W       = 26;
   localparam int CX_W         = 30;
   localparam int Z_W          = 26;
   localparam int SQ_W         = 52;
   localparam int ROOT_W       = 26;
   localparam int NUM_W        = 42;
   localparam int STEP_W       = 6;

   localparam logic [2:0] CSR_GAIN      = 3'd0;
   localparam logic [2:0] CSR_CRUISE    = 3'd1;
   localparam logic [2:0] CSR_THRESHOLD = 3'd2;
   localparam logic [2:0] CSR_RADIUS    = 3'd3;
   localparam logic [2:0] CSR_COUNT     = 3'd4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } waypoint_type;

   function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] i);
      logic [Z_W-1:0] v;
      case (i)
         5'd0:  v = 26'd2097152;
         5'd1:  v = 26'd1238021;
         5'd2:  v = 26'd654136;
         5'd3:  v = 26'd332050;
         5'd4:  v = 26'd166669;
         5'd5:  v = 26'd83416;
         5'd6:  v = 26'd41718;
         5'd7:  v = 26'd20860;
         5'd8:  v = 26'd10430;
         5'd9:  v = 26'd5215;
         5'd10: v = 26'd2608;
         5'd11: v = 26'd1304;
         5'd12: v = 26'd652;
         5'd13: v = 26'd326;
         5'd14: v = 26'd163;
         5'd15: v = 26'd81;
         5'd16: v = 26'd41;
         5'd17: v = 26'd20;
         5'd18: v = 26'd10;
         5'd19: v = 26'd5;
         5'd20: v = 26'd3;
         5'd21: v = 26'd1;
         5'd22: v = 26'd1;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

/* rtl/waypoint_heading_follower.sv */
// sequence: a tick passes through read, difference, two squaring, cordic, square root,
// multiply, divide and finish states before its first result is raised; on arrival a
// second result follows on the next cycle after the first is taken; a waypoint load
// is taken and gives no result; handling: one request at a time, taken only in idle;
// cordic (16 steps), 26-step square root and 42-step divider run in turn
// reset: synchronous active high; returns control to idle, clears target, outputs and step, sets configuration defaults
module waypoint_heading_follower (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[0], slot[3:1], pos_x[27:4], pos_y[51:28], pos_z[75:52], heading[91:76]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // vel_forward[23:0], vel_vertical[47:24], turn_rate[71:48], arrived[72],
   // target_slot[75:73]
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import whf_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_DIFF  = 4'd2;
   localparam logic [3:0] S_SQX   = 4'd3;
   localparam logic [3:0] S_SQY   = 4'd4;
   localparam logic [3:0] S_CORD  = 4'd5;
   localparam logic [3:0] S_SQRT  = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_OUT1  = 4'd10;
   localparam logic [3:0] S_OUT2  = 4'd11;

   // configuration registers
   logic [15:0] gain_ff, cruise_ff, radius_ff;
   logic [14:0] thresh_ff;
   logic [3:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= 16'd256;
         cruise_ff <= 16'd768;
         thresh_ff <= 15'd1043;
         radius_ff <= 16'd256;
         count_ff  <= 4'd5;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN:      gain_ff   <= csr_wdata;
            CSR_CRUISE:    cruise_ff <= csr_wdata;
            CSR_THRESHOLD: thresh_ff <= csr_wdata[14:0];
            CSR_RADIUS:    radius_ff <= csr_wdata;
            CSR_COUNT:     count_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic                    in_cmd;
   logic [SLOT_W-1:0]       in_slot;
   logic signed [POS_W-1:0] in_x, in_y, in_z;
   logic signed [15:0]      in_hd;
   assign in_cmd  = req_tdata[0];
   assign in_slot = req_tdata[3:1];
   assign in_x    = req_tdata[27:4];
   assign in_y    = req_tdata[51:28];
   assign in_z    = req_tdata[75:52];
   assign in_hd   = req_tdata[91:76];

   // waypoint table, registered read
   waypoint_type wp_mem [WAYPOINTS];
   waypoint_type wp_rd_ff;

   logic [3:0] state_ff;
   logic       req_fire;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   logic [SLOT_W-1:0] target_ff;

   always_ff @(posedge clock) begin
      if (req_fire && in_cmd == CMD_LOAD)
         wp_mem[in_slot] <= '{x: in_x, y: in_y, z: in_z};
      wp_rd_ff <= wp_mem[target_ff];
   end

   // working registers
   logic signed [POS_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [15:0]      hd_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]         sum_ff;
   logic signed [CX_W-1:0]  cx_ff, cy_ff;
   logic signed [Z_W-1:0]   cz_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [SQ_W-1:0]         rem_ff;     // sqrt remainder
   logic [ROOT_W-1:0]       root_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [NUM_W-1:0]        quo_ff;
   logic [ROOT_W:0]         drem_ff;
   logic signed [POS_W-1:0] fwd_ff, vert_ff, turn_ff;
   logic                    arrive_ff;
   logic                    rsp_valid_ff, rsp_last_ff;

   // shared multiplier, one product a cycle
   logic signed [DIFF_W:0]  mul_a, mul_b;
   logic signed [2*DIFF_W+1:0] mul_p;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQX: begin
            mul_a = {dx_ff[DIFF_W-1], dx_ff};
            mul_b = {dx_ff[DIFF_W-1], dx_ff};
         end
         S_SQY: begin
            mul_a = {dy_ff[DIFF_W-1], dy_ff};
            mul_b = {dy_ff[DIFF_W-1], dy_ff};
         end
         S_MUL: begin
            mul_a = {11'd0, cruise_ff};
            mul_b = dz_ff[DIFF_W-1] ? -{dz_ff[DIFF_W-1], dz_ff}
                                    : {dz_ff[DIFF_W-1], dz_ff};
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // cordic step
   logic signed [CX_W-1:0] xs, ys;
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;

   // sqrt step, two bits of the radicand a cycle
   logic [ROOT_W+1:0] sq_trial;
   logic [SQ_W-1:0]   sq_rem_sh;
   always_comb begin
      sq_rem_sh = {rem_ff[SQ_W-3:0], 2'b00};
      sq_trial  = {rem_ff[ROOT_W-1:0], sum_ff[SQ_W-1:SQ_W-2]} - {root_ff, 2'b01};
   end

   // divider step
   logic [ROOT_W+1:0] dv_sh;
   logic [ROOT_W+1:0] dv_diff;
   assign dv_sh   = {drem_ff, num_ff[NUM_W-1]};
   assign dv_diff = dv_sh - {2'b00, root_ff};

   // error, turn, vertical and next target
   logic signed [15:0] bear16, err16;
   logic [15:0]        mag16;
   logic signed [Z_W-1:0] zr;
   logic signed [33:0] tprod;
   logic signed [25:0] tsh;
   logic [NUM_W-1:0]   qsat;
   logic [SLOT_W:0]    eff_cnt, nxt_tgt;
   always_comb begin
      zr     = (cz_ff + 26'sd128) >>> 8;
      bear16 = (dx_ff == '0 && dy_ff == '0) ? 16'sd0 : zr[15:0];
      err16  = bear16 - hd_ff;
      mag16  = err16[15] ? 16'(-err16) : err16;
      tprod  = $signed({1'b0, gain_ff}) * err16 + 34'sd128;
      tsh    = tprod[33:8];
      qsat   = (quo_ff > 42'd8388608) ? 42'd8388608 : quo_ff;
      eff_cnt = (count_ff == 4'd0) ? 4'd1 : (count_ff > 4'd8) ? 4'd8 : count_ff;
      nxt_tgt = {1'b0, target_ff} + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= '0;
         fwd_ff       <= '0;
         vert_ff      <= '0;
         turn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         arrive_ff    <= 1'b0;
         step_ff      <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_fire && in_cmd == CMD_TICK) begin
               px_ff <= in_x;
               py_ff <= in_y;
               pz_ff <= in_z;
               hd_ff <= in_hd;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_DIFF;
            S_DIFF: begin
               dx_ff <= DIFF_W'(wp_rd_ff.x) - DIFF_W'(px_ff);
               dy_ff <= DIFF_W'(wp_rd_ff.y) - DIFF_W'(py_ff);
               dz_ff <= DIFF_W'(wp_rd_ff.z) - DIFF_W'(pz_ff);
               state_ff <= S_SQX;
            end
            S_SQX: begin
               sum_ff <= SQ_W'(mul_p);
               // cordic pre-rotation into the right half plane
               if (dx_ff < 0) begin
                  if (dy_ff >= 0) begin
                     cx_ff <= CX_W'(dy_ff);
                     cy_ff <= -CX_W'(dx_ff);
                     cz_ff <= 26'sd4194304;
                  end else begin
                     cx_ff <= -CX_W'(dy_ff);
                     cy_ff <= CX_W'(dx_ff);
                     cz_ff <= -26'sd4194304;
                  end
               end else begin
                  cx_ff <= CX_W'(dx_ff);
                  cy_ff <= CX_W'(dy_ff);
                  cz_ff <= '0;
               end
               state_ff <= S_SQY;
            end
            S_SQY: begin
               sum_ff  <= sum_ff + SQ_W'(mul_p);
               step_ff <= '0;
               state_ff <= S_CORD;
            end
            S_CORD: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + atan_entry(step_ff[4:0]);
               end else begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - atan_entry(step_ff[4:0]);
               end
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  step_ff <= '0;
                  rem_ff  <= '0;
                  root_ff <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_SQRT: begin
               sum_ff <= {sum_ff[SQ_W-3:0], 2'b00};
               if (!sq_trial[ROOT_W+1]) begin
                  rem_ff  <= SQ_W'(sq_trial);
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= sq_rem_sh | SQ_W'(sum_ff[SQ_W-1:SQ_W-2]);
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
               if (step_ff == STEP_W'(ROOT_W - 1)) begin
                  step_ff <= '0;
                  state_ff <= S_MUL;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_MUL: begin
               num_ff  <= NUM_W'(mul_p);
               drem_ff <= '0;
               quo_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               if (!dv_diff[ROOT_W+1]) begin
                  drem_ff <= dv_diff[ROOT_W:0];
                  quo_ff  <= {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  drem_ff <= dv_sh[ROOT_W:0];
                  quo_ff  <= {quo_ff[NUM_W-2:0], 1'b0};
               end
               if (step_ff == STEP_W'(NUM_W - 1)) begin
                  step_ff <= '0;
                  state_ff <= S_FIN;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_FIN: begin
               if (root_ff == '0)
                  vert_ff <= '0;
               else if (dz_ff < 0)
                  vert_ff <= -POS_W'(qsat);
               else if (qsat > 42'd8388607)
                  vert_ff <= 24'sd8388607;
               else
                  vert_ff <= POS_W'(qsat);
               if (mag16 > {1'b0, thresh_ff}) begin
                  if (tsh > 26'sd8388607)       turn_ff <= 24'sd8388607;
                  else if (tsh < -26'sd8388608) turn_ff <= -24'sd8388608;
                  else                          turn_ff <= tsh[23:0];
               end else begin
                  fwd_ff <= POS_W'(cruise_ff);
               end
               arrive_ff    <= (root_ff < ROOT_W'(radius_ff));
               rsp_valid_ff <= 1'b1;
               rsp_last_ff  <= !(root_ff < ROOT_W'(radius_ff));
               state_ff     <= S_OUT1;
            end
            S_OUT1: if (rsp_tready) begin
               if (arrive_ff) begin
                  fwd_ff      <= '0;
                  target_ff   <= (nxt_tgt >= eff_cnt) ? '0 : nxt_tgt[SLOT_W-1:0];
                  rsp_last_ff <= 1'b1;
                  state_ff    <= S_OUT2;
               end else begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            S_OUT2: if (rsp_tready) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, target_ff, arrive_ff, turn_ff, vert_ff, fwd_ff};
endmodule
